[design/cob_pkg.sv]
package cob_pkg;

  localparam int STAMP_W  = 16;
  localparam int NUM_COMP = 3;

  localparam logic [2:0] KIND_ARRIVE = 3'd0;
  localparam logic [2:0] KIND_STORE  = 3'd1;
  localparam logic [2:0] KIND_HELD   = 3'd2;
  localparam logic [2:0] KIND_DROP   = 3'd3;
  localparam logic [2:0] KIND_SENT   = 3'd4;

  typedef logic [NUM_COMP-1:0][STAMP_W-1:0] stamp_t;

  typedef struct packed {
    logic [1:0] from;
    stamp_t     stamp;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic keep;
    logic insert;
  } store_ctl_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [1:0] from;
    stamp_t     clock;
    logic       last;
  } result_t;

  function automatic logic [STAMP_W-1:0] pick_comp(stamp_t s, logic [1:0] idx);
    logic [STAMP_W-1:0] v;
    v = '0;
    for (int k = 0; k < NUM_COMP; k++) begin
      if (idx == 2'(k)) begin
        v = s[k];
      end
    end
    return v;
  endfunction

endpackage

[design/cob_in_if.sv]
interface cob_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [1:0]  sender;
  logic [15:0] stamp_zero;
  logic [15:0] stamp_one;
  logic [15:0] stamp_two;

  modport source (output valid, cmd, sender, stamp_zero, stamp_one, stamp_two, input ready);
  modport sink (input valid, cmd, sender, stamp_zero, stamp_one, stamp_two, output ready);
endinterface

[design/cob_out_if.sv]
interface cob_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [1:0]  from_process;
  logic [15:0] clock_zero;
  logic [15:0] clock_one;
  logic [15:0] clock_two;
  logic        last;

  modport source (output valid, kind, from_process, clock_zero, clock_one, clock_two, last,
                  input ready);
  modport sink (input valid, kind, from_process, clock_zero, clock_one, clock_two, last,
                output ready);
endinterface

[design/causal_order_holdback_top.sv]
// Causal-order delivery of broadcast messages against a local vector clock.
// The request channel carries either a local send event (cmd high) or a
// received message with its sender and vector stamp. The result channel
// returns one or more reports per request; the final one has last set.
// The own_process register is to be written over the APB port only
// while idle; the block itself does not enforce this. One request is
// in work at a time. A send, a held message or a dropped message
// gives its single result via the pending and output registers, and
// the next request is taken in the cycle that result appears. A message
// delivered on arrival rescans the hold-back store, a row of cells that
// rotates past one comparator at its head, if the store is not empty.
// Each pass visits every held entry once; passes repeat while one delivers.
// Every result is staged one step so the last flag is known; a stalled
// result channel holds the rescan at its next delivery.
// Reset clears the clock, the store and own_process to zero.
module causal_order_holdback_top #(
  parameter int HOLD_DEPTH    = 16,
  parameter int NUM_PROCESSES = 3,
  parameter int COUNT_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  cob_in_if.sink      request,
  cob_out_if.source   result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cob_pkg::*;

  localparam int CW = $clog2(HOLD_DEPTH + 1);
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;
  localparam logic [1:0] LAST_PROC = 2'(NUM_PROCESSES - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [1:0] own_process;
  logic [NUM_PROCESSES-1:0][COUNT_BITS-1:0] local_clock;
  logic [NUM_PROCESSES-1:0][COUNT_BITS-1:0] local_clock_next;
  logic [CW-1:0] pass_left;
  logic [CW-1:0] pass_left_next;
  logic [CW-1:0] count;
  logic          progress;
  logic          progress_next;
  logic          full;
  result_t       pend;
  result_t       pend_next;
  result_t       out_res;
  logic          out_valid;
  logic          out_free;
  logic          push;
  logic          push_last;
  entry_t        head;
  entry_t        fill;
  store_ctl_t    ctl;
  stamp_t        req_stamp;
  logic          req_ok;
  logic          head_ok;
  logic [1:0]    me;
  logic [COUNT_BITS-1:0] me_clock;
  logic          upd_en;
  logic [1:0]    upd_idx;
  logic [COUNT_BITS-1:0] upd_val;
  logic          new_res;
  logic [2:0]    new_kind;
  logic [1:0]    new_from;

  assign pready = 1'b1;
  assign prdata = {30'd0, own_process};

  always_ff @(posedge clk) begin
    if (rst) begin
      own_process <= 2'd0;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      own_process <= pwdata[1:0];
    end
  end

  assign req_stamp = {request.stamp_two, request.stamp_one, request.stamp_zero};
  assign me = (own_process >= 2'(NUM_PROCESSES)) ? LAST_PROC : own_process;
  assign request.ready = (state == ST_IDLE);
  assign out_free = !out_valid || result.ready;

  always_comb begin
    me_clock = '0;
    for (int k = 0; k < NUM_PROCESSES; k++) begin
      if (me == 2'(k)) begin
        me_clock = local_clock[k];
      end
    end
  end

  cob_check #(.NUM_PROCESSES(NUM_PROCESSES), .COUNT_BITS(COUNT_BITS)) u_chk_req (
    .sender (request.sender),
    .stamp  (req_stamp),
    .clock  (local_clock),
    .ok     (req_ok)
  );

  cob_check #(.NUM_PROCESSES(NUM_PROCESSES), .COUNT_BITS(COUNT_BITS)) u_chk_head (
    .sender (head.from),
    .stamp  (head.stamp),
    .clock  (local_clock),
    .ok     (head_ok)
  );

  cob_store #(.HOLD_DEPTH(HOLD_DEPTH)) u_store (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .fill  (fill),
    .head  (head),
    .count (count),
    .full  (full)
  );

  always_comb begin
    state_next     = state;
    pass_left_next = pass_left;
    progress_next  = progress;
    ctl            = '0;
    fill           = head;
    upd_en         = 1'b0;
    upd_idx        = me;
    upd_val        = '0;
    new_res        = 1'b0;
    new_kind       = KIND_DROP;
    new_from       = request.sender;
    push           = 1'b0;
    push_last      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (request.valid) begin
          new_res    = 1'b1;
          state_next = ST_FLUSH;
          if (request.cmd) begin
            new_kind = KIND_SENT;
            new_from = me;
            upd_en   = 1'b1;
            upd_idx  = me;
            upd_val  = (me_clock == COUNT_MAX) ? me_clock : me_clock + COUNT_BITS'(1);
          end else if (32'(request.sender) >= NUM_PROCESSES) begin
            new_kind = KIND_DROP;
          end else if (req_ok) begin
            new_kind = KIND_ARRIVE;
            upd_en   = 1'b1;
            upd_idx  = request.sender;
            upd_val  = COUNT_BITS'(pick_comp(req_stamp, request.sender));
            if (count != '0) begin
              state_next     = ST_SCAN;
              pass_left_next = count;
              progress_next  = 1'b0;
            end
          end else if (!full) begin
            new_kind   = KIND_HELD;
            ctl.insert = 1'b1;
            fill.from  = request.sender;
            fill.stamp = req_stamp;
          end else begin
            new_kind = KIND_DROP;
          end
        end
      end
      ST_SCAN: begin
        if (pass_left == '0) begin
          if (progress && count != '0) begin
            pass_left_next = count;
            progress_next  = 1'b0;
          end else begin
            state_next = ST_FLUSH;
          end
        end else if (!head_ok) begin
          ctl.shift      = 1'b1;
          ctl.keep       = 1'b1;
          pass_left_next = pass_left - CW'(1);
        end else if (out_free) begin
          ctl.shift      = 1'b1;
          pass_left_next = pass_left - CW'(1);
          progress_next  = 1'b1;
          upd_en         = 1'b1;
          upd_idx        = head.from;
          upd_val        = COUNT_BITS'(pick_comp(head.stamp, head.from));
          push           = 1'b1;
          new_res        = 1'b1;
          new_kind       = KIND_STORE;
          new_from       = head.from;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          push       = 1'b1;
          push_last  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    for (int k = 0; k < NUM_PROCESSES; k++) begin
      local_clock_next[k] = (upd_en && upd_idx == 2'(k)) ? upd_val : local_clock[k];
    end
  end

  always_comb begin
    pend_next = pend;
    if (new_res) begin
      pend_next.kind  = new_kind;
      pend_next.from  = new_from;
      pend_next.clock = '0;
      pend_next.last  = 1'b0;
      for (int k = 0; k < NUM_PROCESSES; k++) begin
        pend_next.clock[k] = STAMP_W'(local_clock_next[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      pass_left   <= '0;
      progress    <= 1'b0;
      local_clock <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      pass_left   <= pass_left_next;
      progress    <= progress_next;
      local_clock <= local_clock_next;
      if (push) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend <= pend_next;
    if (push) begin
      out_res <= '{kind: pend.kind, from: pend.from, clock: pend.clock, last: push_last};
    end
  end

  assign result.valid        = out_valid;
  assign result.kind         = out_res.kind;
  assign result.from_process = out_res.from;
  assign result.clock_zero   = out_res.clock[0];
  assign result.clock_one    = out_res.clock[1];
  assign result.clock_two    = out_res.clock[2];
  assign result.last         = out_res.last;

endmodule

[design/cob_check.sv]
module cob_check #(
  parameter int NUM_PROCESSES = 3,
  parameter int COUNT_BITS    = 16
) (
  input  logic [1:0]                                sender,
  input  cob_pkg::stamp_t                           stamp,
  input  logic [NUM_PROCESSES-1:0][COUNT_BITS-1:0]  clock,
  output logic                                      ok
);
  import cob_pkg::*;

  localparam int CMP_W = (COUNT_BITS > STAMP_W ? COUNT_BITS : STAMP_W) + 1;
  localparam logic [CMP_W-1:0] COUNT_MAX = CMP_W'((64'd1 << COUNT_BITS) - 64'd1);

  always_comb begin
    logic [CMP_W-1:0] va;
    logic [CMP_W-1:0] ca;
    ok = (32'(sender) < NUM_PROCESSES);
    for (int k = 0; k < NUM_PROCESSES; k++) begin
      va = CMP_W'(stamp[k]);
      ca = CMP_W'(clock[k]);
      if (sender == 2'(k)) begin
        if (va > COUNT_MAX || va != ca + CMP_W'(1)) begin
          ok = 1'b0;
        end
      end else if (va > ca) begin
        ok = 1'b0;
      end
    end
  end

endmodule

[design/cob_cell.sv]
module cob_cell (
  input  logic                clk,
  input  logic                rst,
  input  cob_pkg::store_ctl_t ctl,
  input  logic                prev_valid,
  input  logic                up_valid,
  input  cob_pkg::entry_t     up_entry,
  input  cob_pkg::entry_t     fill,
  output logic                valid,
  output cob_pkg::entry_t     entry
);
  import cob_pkg::*;

  logic take_up;
  logic take_fill;
  logic valid_next;

  always_comb begin
    take_up   = ctl.shift && up_valid;
    take_fill = (ctl.shift && ctl.keep && valid && !up_valid) ||
                (!ctl.shift && ctl.insert && !valid && prev_valid);
    valid_next = valid;
    if (ctl.shift) begin
      valid_next = up_valid || take_fill;
    end else if (take_fill) begin
      valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take_up) begin
      entry <= up_entry;
    end else if (take_fill) begin
      entry <= fill;
    end
  end

endmodule

[design/cob_store.sv]
module cob_store #(
  parameter int HOLD_DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  cob_pkg::store_ctl_t                ctl,
  input  cob_pkg::entry_t                    fill,
  output cob_pkg::entry_t                    head,
  output logic [$clog2(HOLD_DEPTH+1)-1:0]    count,
  output logic                               full
);
  import cob_pkg::*;

  localparam int CW = $clog2(HOLD_DEPTH + 1);

  logic [HOLD_DEPTH-1:0] valid;
  entry_t                entries [HOLD_DEPTH];

  for (genvar j = 0; j < HOLD_DEPTH; j++) begin : g_cell
    logic   prev_v;
    logic   up_v;
    entry_t up_e;
    if (j == 0) begin : g_first
      assign prev_v = 1'b1;
    end else begin : g_mid
      assign prev_v = valid[j-1];
    end
    if (j == HOLD_DEPTH - 1) begin : g_last
      assign up_v = 1'b0;
      assign up_e = '0;
    end else begin : g_inner
      assign up_v = valid[j+1];
      assign up_e = entries[j+1];
    end
    cob_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .prev_valid (prev_v),
      .up_valid   (up_v),
      .up_entry   (up_e),
      .fill       (fill),
      .valid      (valid[j]),
      .entry      (entries[j])
    );
  end

  assign head = entries[0];
  assign full = (count == CW'(HOLD_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.shift && !ctl.keep) begin
      count <= count - CW'(1);
    end else if (!ctl.shift && ctl.insert && !full) begin
      count <= count + CW'(1);
    end
  end

endmodule

[design/cob_checker.sv]
module cob_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [2:0]  res_kind,
  input logic [1:0]  res_from,
  input logic [15:0] res_clock_zero,
  input logic [15:0] res_clock_one,
  input logic [15:0] res_clock_two,
  input logic        res_last
);
  import cob_pkg::*;

  // Only one request is in work at a time.
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in work");

  // While a result without last is shown, more results are owed, so no new request.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_last |-> !req_ready)
    else $error("request channel opened before the last result");

  // A send gives exactly one result.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_kind == KIND_SENT |-> res_last)
    else $error("send result without last");

  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_kind) && $stable(res_from) &&
      $stable(res_clock_zero) && $stable(res_clock_one) && $stable(res_clock_two) &&
      $stable(res_last))
    else $error("stalled result changed");

endmodule

bind causal_order_holdback_top cob_checker u_cob_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (request.valid),
  .req_ready      (request.ready),
  .res_valid      (result.valid),
  .res_ready      (result.ready),
  .res_kind       (result.kind),
  .res_from       (result.from_process),
  .res_clock_zero (result.clock_zero),
  .res_clock_one  (result.clock_one),
  .res_clock_two  (result.clock_two),
  .res_last       (result.last)
);

[test/causal_order_holdback_top_tb.sv]
module causal_order_holdback_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cob_pkg::*;

  localparam int HOLD_DEPTH = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [2:0] ADDR_OWN_PROCESS = 3'd0;
  localparam bit CMD_RECEIVE = 1'b0;
  localparam bit CMD_SEND = 1'b1;
  localparam logic [1:0] BAD_SENDER = 2'd3;
  localparam logic [15:0] COUNT_TOP = 16'hFFFF;

  typedef struct packed {
    bit          cmd;
    logic [1:0]  sender;
    logic [15:0] s0;
    logic [15:0] s1;
    logic [15:0] s2;
    bit          typed;
    logic [2:0]  kind;
    logic [1:0]  from;
    logic [15:0] c0;
    logic [15:0] c1;
    logic [15:0] c2;
  } row_t;

  // Rows with typed set carry their single expected report; the others use the predictor.
  localparam row_t DIRECTED [25] = '{
    '{CMD_SEND, 2'd0, 16'h0, 16'h0, 16'h0, 1'b1, KIND_SENT, 2'd0, 16'd1, 16'd0, 16'd0},
    '{CMD_RECEIVE, BAD_SENDER, 16'hFFFF, 16'hFFFF, 16'hFFFF,
      1'b1, KIND_DROP, BAD_SENDER, 16'd1, 16'd0, 16'd0},
    '{CMD_RECEIVE, 2'd1, 16'h0, 16'h2, 16'h0, 1'b1, KIND_HELD, 2'd1, 16'd1, 16'd0, 16'd0},
    '{CMD_RECEIVE, 2'd2, 16'h1, 16'h2, 16'h1, 1'b1, KIND_HELD, 2'd2, 16'd1, 16'd0, 16'd0},
    '{CMD_RECEIVE, 2'd1, 16'h1, 16'h1, 16'h0, 1'b0, KIND_ARRIVE, 2'd0, 16'd0, 16'd0, 16'd0},
    '{CMD_RECEIVE, 2'd0, 16'h0, 16'h0, 16'h0, 1'b1, KIND_HELD, 2'd0, 16'd1, 16'd2, 16'd1},
    '{CMD_RECEIVE, 2'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
      1'b1, KIND_HELD, 2'd0, 16'd1, 16'd2, 16'd1},
    '{CMD_RECEIVE, 2'd1, 16'h0, 16'h0, 16'h0, 1'b1, KIND_HELD, 2'd1, 16'd1, 16'd2, 16'd1},
    '{CMD_RECEIVE, 2'd1, 16'hFFFF, 16'h0, 16'h0, 1'b1, KIND_HELD, 2'd1, 16'd1, 16'd2, 16'd1},
    '{CMD_RECEIVE, 2'd2, 16'h0, 16'h0, 16'h0, 1'b1, KIND_HELD, 2'd2, 16'd1, 16'd2, 16'd1},
    '{CMD_RECEIVE, 2'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF,
      1'b1, KIND_HELD, 2'd2, 16'd1, 16'd2, 16'd1},
    '{CMD_RECEIVE, 2'd0, 16'h3, 16'h0, 16'h0, 1'b1, KIND_HELD, 2'd0, 16'd1, 16'd2, 16'd1},
    '{CMD_RECEIVE, 2'd1, 16'h0, 16'h4, 16'h0, 1'b1, KIND_HELD, 2'd1, 16'd1, 16'd2, 16'd1},
    '{CMD_RECEIVE, 2'd2, 16'h0, 16'h0, 16'h3, 1'b1, KIND_HELD, 2'd2, 16'd1, 16'd2, 16'd1},
    '{CMD_RECEIVE, 2'd1, 16'h3, 16'h3, 16'h1, 1'b1, KIND_HELD, 2'd1, 16'd1, 16'd2, 16'd1},
    '{CMD_RECEIVE, 2'd0, 16'hAAAA, 16'h5555, 16'hAAAA,
      1'b1, KIND_HELD, 2'd0, 16'd1, 16'd2, 16'd1},
    '{CMD_RECEIVE, 2'd1, 16'h5555, 16'hAAAA, 16'h5555,
      1'b1, KIND_HELD, 2'd1, 16'd1, 16'd2, 16'd1},
    '{CMD_RECEIVE, 2'd2, 16'h2, 16'h2, 16'h2, 1'b1, KIND_HELD, 2'd2, 16'd1, 16'd2, 16'd1},
    '{CMD_RECEIVE, 2'd0, 16'h8000, 16'h0, 16'h0, 1'b1, KIND_HELD, 2'd0, 16'd1, 16'd2, 16'd1},
    '{CMD_RECEIVE, 2'd1, 16'h0, 16'h8000, 16'h0, 1'b1, KIND_HELD, 2'd1, 16'd1, 16'd2, 16'd1},
    '{CMD_RECEIVE, 2'd2, 16'h0, 16'h0, 16'h8000, 1'b1, KIND_HELD, 2'd2, 16'd1, 16'd2, 16'd1},
    '{CMD_RECEIVE, 2'd1, 16'h7FFF, 16'h7FFF, 16'h7FFF,
      1'b1, KIND_DROP, 2'd1, 16'd1, 16'd2, 16'd1},
    '{CMD_RECEIVE, 2'd0, 16'h2, 16'h0, 16'h0, 1'b0, KIND_ARRIVE, 2'd0, 16'd0, 16'd0, 16'd0},
    '{CMD_SEND, 2'd0, 16'h0, 16'h0, 16'h0, 1'b0, KIND_ARRIVE, 2'd0, 16'd0, 16'd0, 16'd0},
    '{CMD_RECEIVE, BAD_SENDER, 16'h0, 16'h0, 16'h0,
      1'b0, KIND_ARRIVE, 2'd0, 16'd0, 16'd0, 16'd0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  cob_in_if  request_ch ();
  cob_out_if result_ch ();

  causal_order_holdback_top i_dut (
    .clk     (clk),
    .rst     (rst),
    .request (request_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  stamp_t     vclock;
  entry_t     holdback[$];
  logic [1:0] own_idx;
  result_t    awaited_reports[$];
  int         mismatch_count;
  int         idle_span;
  int         ready_span;
  bit         no_idling;

  always #1 clk = ~clk;

  function automatic result_t make_report(logic [2:0] kind, logic [1:0] from);
    result_t r;
    r.kind = kind;
    r.from = from;
    r.clock = vclock;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic bit deliverable(logic [1:0] s, stamp_t v);
    if (int'(s) >= NUM_COMP) return 1'b0;
    if ({1'b0, v[s]} != {1'b0, vclock[s]} + 17'd1) return 1'b0;
    for (int k = 0; k < NUM_COMP; k++) begin
      if (k != int'(s) && v[k] > vclock[k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic predict_delivery(input bit cmd, input logic [1:0] s, input stamp_t v,
                                  output result_t batch[$]);
    logic [1:0] me;
    bit         progress;
    int         i;
    entry_t     e;
    batch = {};
    if (cmd == CMD_SEND) begin
      me = (int'(own_idx) >= NUM_COMP) ? 2'(NUM_COMP - 1) : own_idx;
      if (vclock[me] != COUNT_TOP) vclock[me] = vclock[me] + 16'd1;
      batch.push_back(make_report(KIND_SENT, me));
    end else if (int'(s) >= NUM_COMP) begin
      batch.push_back(make_report(KIND_DROP, s));
    end else if (deliverable(s, v)) begin
      vclock[s] = v[s];
      batch.push_back(make_report(KIND_ARRIVE, s));
      progress = 1'b1;
      while (progress) begin
        progress = 1'b0;
        i = 0;
        while (i < holdback.size()) begin
          e = holdback[i];
          if (deliverable(e.from, e.stamp)) begin
            vclock[e.from] = e.stamp[e.from];
            batch.push_back(make_report(KIND_STORE, e.from));
            holdback.delete(i);
            progress = 1'b1;
          end else begin
            i++;
          end
        end
      end
    end else if (holdback.size() < HOLD_DEPTH) begin
      e.from = s;
      e.stamp = v;
      holdback.push_back(e);
      batch.push_back(make_report(KIND_HELD, s));
    end else begin
      batch.push_back(make_report(KIND_DROP, s));
    end
    batch[batch.size() - 1].last = 1'b1;
  endtask

  function automatic string show(result_t r);
    return $sformatf("kind %0d from %0d clock %0d/%0d/%0d last %0d",
                     r.kind, r.from, r.clock[0], r.clock[1], r.clock[2], r.last);
  endfunction

  task automatic issue(input bit cmd, input logic [1:0] sender, input stamp_t stamp,
                       input bit typed, input result_t typed_report);
    result_t batch[$];
    @(negedge clk);
    request_ch.valid <= 1'b1;
    request_ch.cmd <= cmd;
    request_ch.sender <= sender;
    request_ch.stamp_zero <= stamp[0];
    request_ch.stamp_one <= stamp[1];
    request_ch.stamp_two <= stamp[2];
    do @(posedge clk); while (request_ch.ready !== 1'b1);
    predict_delivery(cmd, sender, stamp, batch);
    if (typed) begin
      awaited_reports.push_back(typed_report);
    end else begin
      foreach (batch[j]) awaited_reports.push_back(batch[j]);
    end
  endtask

  task automatic pause_sender(input int cycles);
    @(negedge clk);
    request_ch.valid <= 1'b0;
    request_ch.cmd <= 1'($urandom);
    request_ch.sender <= 2'($urandom);
    request_ch.stamp_zero <= 16'($urandom);
    request_ch.stamp_one <= 16'($urandom);
    request_ch.stamp_two <= 16'($urandom);
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic maybe_pause();
    if (!no_idling && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 18));
  endtask

  task automatic wait_drained();
    pause_sender(1);
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_own_process(input logic [1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_OWN_PROCESS;
    pwdata <= {30'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    own_idx = value;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic random_request();
    int     pick;
    int     lag;
    logic [1:0] s;
    stamp_t st;
    pick = $urandom_range(0, 9);
    st = 48'({$urandom, $urandom});
    if (pick < 2) begin
      issue(CMD_SEND, 2'($urandom), st, 1'b0, '0);
    end else if (pick < 3) begin
      issue(CMD_RECEIVE, 2'($urandom_range(0, 3)), st, 1'b0, '0);
    end else begin
      s = 2'($urandom_range(0, NUM_COMP - 1));
      for (int k = 0; k < NUM_COMP; k++) begin
        if (k == int'(s)) begin
          st[k] = vclock[k] + 16'd1;
          if ($urandom_range(0, 3) == 0) st[k] = st[k] + 16'($urandom_range(1, 2));
        end else begin
          lag = (vclock[k] < 16'd2) ? int'(vclock[k]) : 2;
          st[k] = vclock[k] - 16'($urandom_range(0, lag));
          if ($urandom_range(0, 6) == 0) st[k] = vclock[k] + 16'd1;
        end
      end
      issue(CMD_RECEIVE, s, st, 1'b0, '0);
    end
  endtask

  always @(negedge clk) begin
    if (no_idling) begin
      result_ch.ready <= 1'b1;
    end else if (ready_span > 0) begin
      ready_span--;
    end else begin
      result_ch.ready <= ($urandom_range(0, 2) != 0);
      ready_span = $urandom_range(0, 17);
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      got.kind = result_ch.kind;
      got.from = result_ch.from_process;
      got.clock = {result_ch.clock_two, result_ch.clock_one, result_ch.clock_zero};
      got.last = result_ch.last;
      if (awaited_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Unexpected report: %s", show(got));
      end else begin
        want = awaited_reports.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Report mismatch: expected %s, got %s", show(want), show(got));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((request_ch.valid === 1'b1 && request_ch.ready === 1'b1) ||
        (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) ||
        (psel === 1'b1 && penable === 1'b1)) begin
      idle_span = 0;
    end else begin
      idle_span++;
    end
    if (idle_span >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    stamp_t st;
    request_ch.valid = 1'b0;
    request_ch.cmd = 1'b0;
    request_ch.sender = 2'd0;
    request_ch.stamp_zero = 16'd0;
    request_ch.stamp_one = 16'd0;
    request_ch.stamp_two = 16'd0;
    result_ch.ready = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 3'd0;
    pwdata = 32'd0;
    vclock = '0;
    holdback = {};
    own_idx = 2'd0;
    mismatch_count = 0;
    idle_span = 0;
    ready_span = 0;
    no_idling = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_own_process(2'd0);
    foreach (DIRECTED[i]) begin
      maybe_pause();
      issue(DIRECTED[i].cmd, DIRECTED[i].sender,
            {DIRECTED[i].s2, DIRECTED[i].s1, DIRECTED[i].s0}, DIRECTED[i].typed,
            '{DIRECTED[i].kind, DIRECTED[i].from,
              {DIRECTED[i].c2, DIRECTED[i].c1, DIRECTED[i].c0}, 1'b1});
    end

    wait_drained();
    write_own_process(2'd1);
    repeat (44) begin
      maybe_pause();
      random_request();
    end

    wait_drained();
    write_own_process(2'd3);
    for (int n = 0; n < 44; n++) begin
      if (n == 22) wait_drained();
      maybe_pause();
      random_request();
    end

    // Run sends and receives back to back with both sides running flat out.
    wait_drained();
    write_own_process(2'd2);
    no_idling = 1'b1;
    repeat (12) issue(CMD_SEND, 2'($urandom), '0, 1'b0, '0);
    st = vclock;
    st[2] = COUNT_TOP;
    issue(CMD_RECEIVE, 2'd2, st, 1'b0, '0);
    st = vclock;
    st[0] = vclock[0] + 16'd1;
    issue(CMD_RECEIVE, 2'd0, st, 1'b0, '0);

    pause_sender(1);
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && awaited_reports.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
design/cob_pkg.sv
design/cob_in_if.sv
design/cob_out_if.sv
design/cob_check.sv
design/cob_cell.sv
design/cob_store.sv
design/causal_order_holdback_top.sv
design/cob_checker.sv
test/causal_order_holdback_top_tb.sv
